// ===== rtl/ecis_pkg.sv =====
package ecis_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int MAX_TERMS_DEF = 12;

  localparam int IN_W  = 31;
  localparam int OUT_W = 31;
  localparam int QW    = 64;
  localparam int QB    = 56;
  localparam int TIX_W = 5;
  localparam int PC_W  = 4;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [QW-1:0]        qu_t;
  typedef logic [TIX_W-1:0]     tix_t;
  typedef logic [PC_W-1:0]      pc_t;

  localparam qu_t Q_ONE  = qu_t'(1) << QB;
  localparam qu_t K_241  = (qu_t'(241) << QB) / qu_t'(100);
  localparam qu_t K_715  = (qu_t'(143) << QB) / qu_t'(20);
  localparam qu_t K_700  = qu_t'(7) << QB;
  localparam qu_t K_TINY = Q_ONE / qu_t'(4000);

  localparam int N_MIN = 2;

  typedef enum logic [2:0] {
    UC_MUL,
    UC_BR_RANGE,
    UC_BR_TINY,
    UC_TERMS,
    UC_BR_LOOP,
    UC_TINY,
    UC_OUT
  } uc_op_e;

  typedef enum logic [3:0] {
    OPD_A,
    OPD_A2,
    OPD_NA2,
    OPD_SUM,
    OPD_T1,
    OPD_K715,
    OPD_K241,
    OPD_RFIRST,
    OPD_RSTEP
  } opd_e;

  typedef enum logic [2:0] {
    DST_A2,
    DST_T1,
    DST_T2,
    DST_SUM,
    DST_RES
  } dst_e;

  typedef struct packed {
    uc_op_e op;
    opd_e   src_a;
    opd_e   src_b;
    dst_e   dst;
    logic   jmp;
    pc_t    target;
  } uc_word_t;

  localparam pc_t PC_RANGE = 4'd0;
  localparam pc_t PC_SQ    = 4'd1;
  localparam pc_t PC_TTINY = 4'd2;
  localparam pc_t PC_V1    = 4'd3;
  localparam pc_t PC_V2    = 4'd4;
  localparam pc_t PC_TERMS = 4'd5;
  localparam pc_t PC_FIRST = 4'd6;
  localparam pc_t PC_LOOP  = 4'd7;
  localparam pc_t PC_STEP  = 4'd8;
  localparam pc_t PC_ACC   = 4'd9;
  localparam pc_t PC_FINAL = 4'd10;
  localparam pc_t PC_TINY  = 4'd11;
  localparam pc_t PC_OUT   = 4'd12;

  function automatic uc_word_t uc_rom(input pc_t pc);
    uc_word_t w;
    w.op     = UC_OUT;
    w.src_a  = OPD_A;
    w.src_b  = OPD_A;
    w.dst    = DST_A2;
    w.jmp    = 1'b0;
    w.target = PC_OUT;
    case (pc)
      PC_RANGE: begin
        w.op = UC_BR_RANGE;
      end
      PC_SQ: begin
        w.op = UC_MUL; w.src_a = OPD_A; w.src_b = OPD_A; w.dst = DST_A2;
      end
      PC_TTINY: begin
        w.op = UC_BR_TINY; w.target = PC_TINY;
      end
      PC_V1: begin
        w.op = UC_MUL; w.src_a = OPD_K715; w.src_b = OPD_A; w.dst = DST_T1;
      end
      PC_V2: begin
        w.op = UC_MUL; w.src_a = OPD_K241; w.src_b = OPD_A2; w.dst = DST_T2;
      end
      PC_TERMS: begin
        w.op = UC_TERMS;
      end
      PC_FIRST: begin
        w.op = UC_MUL; w.src_a = OPD_NA2; w.src_b = OPD_RFIRST; w.dst = DST_SUM;
      end
      PC_LOOP: begin
        w.op = UC_BR_LOOP; w.target = PC_FINAL;
      end
      PC_STEP: begin
        w.op = UC_MUL; w.src_a = OPD_NA2; w.src_b = OPD_RSTEP; w.dst = DST_T1;
      end
      PC_ACC: begin
        w.op = UC_MUL; w.src_a = OPD_SUM; w.src_b = OPD_T1; w.dst = DST_SUM;
        w.jmp = 1'b1; w.target = PC_LOOP;
      end
      PC_FINAL: begin
        w.op = UC_MUL; w.src_a = OPD_A2; w.src_b = OPD_SUM; w.dst = DST_RES;
        w.jmp = 1'b1; w.target = PC_OUT;
      end
      PC_TINY: begin
        w.op = UC_TINY;
      end
      PC_OUT: begin
        w.op = UC_OUT;
      end
      default: begin
        w.op = UC_OUT;
      end
    endcase
    return w;
  endfunction

  // 1/(k*k*(k-1)), k = 2j
  function automatic qu_t recip_first(input tix_t j);
    qu_t r;
    case (j)
      5'd2:    r = Q_ONE / 64'd48;
      5'd3:    r = Q_ONE / 64'd180;
      5'd4:    r = Q_ONE / 64'd448;
      5'd5:    r = Q_ONE / 64'd900;
      5'd6:    r = Q_ONE / 64'd1584;
      5'd7:    r = Q_ONE / 64'd2548;
      5'd8:    r = Q_ONE / 64'd3840;
      5'd9:    r = Q_ONE / 64'd5508;
      5'd10:   r = Q_ONE / 64'd7600;
      5'd11:   r = Q_ONE / 64'd10164;
      5'd12:   r = Q_ONE / 64'd13248;
      5'd13:   r = Q_ONE / 64'd16900;
      5'd14:   r = Q_ONE / 64'd21168;
      5'd15:   r = Q_ONE / 64'd26100;
      5'd16:   r = Q_ONE / 64'd31744;
      default: r = '0;
    endcase
    return r;
  endfunction

  // 1/(k*(k-1)), k = 2j
  function automatic qu_t recip_step(input tix_t j);
    qu_t r;
    case (j)
      5'd2:    r = Q_ONE / 64'd12;
      5'd3:    r = Q_ONE / 64'd30;
      5'd4:    r = Q_ONE / 64'd56;
      5'd5:    r = Q_ONE / 64'd90;
      5'd6:    r = Q_ONE / 64'd132;
      5'd7:    r = Q_ONE / 64'd182;
      5'd8:    r = Q_ONE / 64'd240;
      5'd9:    r = Q_ONE / 64'd306;
      5'd10:   r = Q_ONE / 64'd380;
      5'd11:   r = Q_ONE / 64'd462;
      5'd12:   r = Q_ONE / 64'd552;
      5'd13:   r = Q_ONE / 64'd650;
      5'd14:   r = Q_ONE / 64'd756;
      5'd15:   r = Q_ONE / 64'd870;
      5'd16:   r = Q_ONE / 64'd992;
      default: r = '0;
    endcase
    return r;
  endfunction

  // 1/(k-2), k = 2j
  function automatic qu_t recip_add(input tix_t j);
    qu_t r;
    case (j)
      5'd2:    r = Q_ONE / 64'd2;
      5'd3:    r = Q_ONE / 64'd4;
      5'd4:    r = Q_ONE / 64'd6;
      5'd5:    r = Q_ONE / 64'd8;
      5'd6:    r = Q_ONE / 64'd10;
      5'd7:    r = Q_ONE / 64'd12;
      5'd8:    r = Q_ONE / 64'd14;
      5'd9:    r = Q_ONE / 64'd16;
      5'd10:   r = Q_ONE / 64'd18;
      5'd11:   r = Q_ONE / 64'd20;
      5'd12:   r = Q_ONE / 64'd22;
      5'd13:   r = Q_ONE / 64'd24;
      5'd14:   r = Q_ONE / 64'd26;
      5'd15:   r = Q_ONE / 64'd28;
      5'd16:   r = Q_ONE / 64'd30;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/entire_cosine_integral_series.sv =====
// Cin(x) by a microcoded Horner series on one shared 32x32 multiplier.
// Each 64-bit product runs through issue, four partials, a final add and writeback.
// The term count is clamped to 2..MAX_TERMS; out-of-range arguments go straight to the
// output step, tiny ones skip the series. Next input beat taken once the result is loaded;
// the sequencer holds in its output step while a waiting result beat is stalled.
// Reset (rst_ni low, asynchronous): sequencer idle, no result pending.
module entire_cosine_integral_series
  import ecis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [IN_W-1:0] x_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OUT_W-1:0]       cin_value_o,
  output logic                   range_error_o
);

  localparam int  JW          = $clog2(MAX_TERMS + 1);
  localparam int  NT_W        = QW - QB - 1;
  localparam int  Q_SHL       = (FRAC_BITS <= QB) ? (QB - FRAC_BITS) : 0;
  localparam int  Q_SHR       = (FRAC_BITS > QB) ? (FRAC_BITS - QB) : 0;
  localparam qu_t LIMIT       = qu_t'(7) << (FRAC_BITS - 1);
  localparam qu_t OUT_MAX     = qu_t'({OUT_W{1'b1}});
  localparam logic [IN_W:0] IN_MOD = (IN_W + 1)'(1) << IN_W;
  localparam logic [2:0] MSTEP_LAST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_MUL  = 3'b100
  } state_e;

  function automatic qu_t mag64(input q_t v);
    return v[QW-1] ? (qu_t'(0) - qu_t'(v)) : qu_t'(v);
  endfunction

  function automatic q_t pick(input opd_e s, input q_t a, input q_t a2, input q_t sum,
                              input q_t t1, input tix_t jx);
    q_t r;
    case (s)
      OPD_A:      r = a;
      OPD_A2:     r = a2;
      OPD_NA2:    r = -a2;
      OPD_SUM:    r = sum;
      OPD_T1:     r = t1;
      OPD_K715:   r = q_t'(K_715);
      OPD_K241:   r = q_t'(K_241);
      OPD_RFIRST: r = q_t'(recip_first(jx));
      OPD_RSTEP:  r = q_t'(recip_step(jx));
      default:    r = '0;
    endcase
    return r;
  endfunction

  state_e            state_q, state_d;
  pc_t               pc_q, pc_d;
  logic [2:0]        mstep_q, mstep_d;
  logic [JW-1:0]     j_q, j_d;
  logic              out_valid_q, out_valid_d;

  logic              rng_q, rng_d;
  q_t                a_q, a_d, a2_q, a2_d, t1_q, t1_d, t2_q, t2_d;
  q_t                sum_q, sum_d, res_q, res_d;
  qu_t               ma_q, ma_d, mb_q, mb_d;
  logic              neg_q, neg_d;
  logic [QW-1:0]     pp_q, pp_d;
  logic [1:0]        pp_sh_q, pp_sh_d;
  logic [2*QW-1:0]   acc_q, acc_d;
  logic [OUT_W-1:0]  cin_q, cin_d;
  logic              rerr_q, rerr_d;

  uc_word_t          uw;
  tix_t              jx;
  q_t                opa, opb, prod, v;
  logic [31:0]       pa, pb;
  logic [2*QW-1:0]   addend;
  logic              psat;
  logic [QW-2:0]     pmag;
  logic [NT_W-1:0]   nt, ntc;
  logic [IN_W:0]     mag;
  qu_t               r64;
  logic              out_free;

  assign uw  = uc_rom(pc_q);
  assign jx  = TIX_W'(j_q);
  assign opa = pick(uw.src_a, a_q, a2_q, sum_q, t1_q, jx);
  assign opb = pick(uw.src_b, a_q, a2_q, sum_q, t1_q, jx);

  assign pa = mstep_q[1] ? ma_q[QW-1:32] : ma_q[31:0];
  assign pb = mstep_q[0] ? mb_q[QW-1:32] : mb_q[31:0];

  always_comb begin
    case (pp_sh_q)
      2'd0:    addend = {{QW{1'b0}}, pp_q};
      2'd1:    addend = {32'b0, pp_q, 32'b0};
      2'd2:    addend = {pp_q, {QW{1'b0}}};
      default: addend = '0;
    endcase
  end

  assign psat = |acc_q[2*QW-1:QB+QW-1];
  assign pmag = psat ? {(QW-1){1'b1}} : acc_q[QB+QW-2:QB];
  assign prod = neg_q ? -q_t'({1'b0, pmag}) : q_t'({1'b0, pmag});

  assign v = q_t'(K_700) + t1_q - t2_q;

  always_comb begin
    nt = v[QW-1] ? '0 : v[QW-2:QB];
    if (nt < NT_W'(N_MIN)) begin
      ntc = NT_W'(N_MIN);
    end else if (nt > NT_W'(MAX_TERMS)) begin
      ntc = NT_W'(MAX_TERMS);
    end else begin
      ntc = nt;
    end
  end

  assign mag      = x_value_i[IN_W-1] ? (IN_MOD - {1'b0, $unsigned(x_value_i)})
                                      : {1'b0, $unsigned(x_value_i)};
  assign r64      = (qu_t'(res_q) >> Q_SHL) << Q_SHR;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    mstep_d     = mstep_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && out_stall_i;
    rng_d       = rng_q;
    a_d         = a_q;
    a2_d        = a2_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    sum_d       = sum_q;
    res_d       = res_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    neg_d       = neg_q;
    pp_d        = pp_q;
    pp_sh_d     = pp_sh_q;
    acc_d       = acc_q;
    cin_d       = cin_q;
    rerr_d      = rerr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rng_d   = qu_t'(mag) > LIMIT;
          a_d     = q_t'((qu_t'(mag) << Q_SHL) >> Q_SHR);
          pc_d    = PC_RANGE;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        pc_d = pc_q + pc_t'(1);
        case (uw.op)
          UC_MUL: begin
            ma_d    = mag64(opa);
            mb_d    = mag64(opb);
            neg_d   = opa[QW-1] ^ opb[QW-1];
            acc_d   = '0;
            pp_d    = '0;
            pp_sh_d = '0;
            mstep_d = '0;
            pc_d    = pc_q;
            state_d = ST_MUL;
          end
          UC_BR_RANGE: begin
            if (rng_q) pc_d = uw.target;
          end
          UC_BR_TINY: begin
            if (a_q < q_t'(K_TINY)) pc_d = uw.target;
          end
          UC_TERMS: begin
            j_d = JW'(ntc);
          end
          UC_BR_LOOP: begin
            if (j_q < JW'(N_MIN)) pc_d = uw.target;
          end
          UC_TINY: begin
            res_d = a2_q >>> 2;
          end
          UC_OUT: begin
            pc_d = pc_q;
            if (out_free) begin
              out_valid_d = 1'b1;
              rerr_d      = rng_q;
              cin_d       = rng_q ? '0 : ((r64 > OUT_MAX) ? OUT_MAX[OUT_W-1:0]
                                                          : r64[OUT_W-1:0]);
              state_d     = ST_IDLE;
            end
          end
          default: begin
            pc_d = PC_OUT;
          end
        endcase
      end
      ST_MUL: begin
        if (mstep_q == MSTEP_LAST) begin
          case (uw.dst)
            DST_A2: a2_d = prod;
            DST_T1: t1_d = prod;
            DST_T2: t2_d = prod;
            DST_SUM: begin
              sum_d = prod + q_t'(recip_add(jx));
              j_d   = j_q - JW'(1);
            end
            DST_RES: res_d = prod[QW-1] ? '0 : (prod >>> 1);
            default: res_d = res_q;
          endcase
          pc_d    = uw.jmp ? uw.target : pc_q + pc_t'(1);
          state_d = ST_RUN;
        end else begin
          acc_d   = acc_q + addend;
          mstep_d = mstep_q + 3'd1;
          if (!mstep_q[2]) begin
            pp_d    = QW'(pa) * QW'(pb);
            pp_sh_d = {1'b0, mstep_q[1]} + {1'b0, mstep_q[0]};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= PC_RANGE;
      mstep_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      mstep_q     <= mstep_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rng_q   <= rng_d;
    a_q     <= a_d;
    a2_q    <= a2_d;
    t1_q    <= t1_d;
    t2_q    <= t2_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    neg_q   <= neg_d;
    pp_q    <= pp_d;
    pp_sh_q <= pp_sh_d;
    acc_q   <= acc_d;
    cin_q   <= cin_d;
    rerr_q  <= rerr_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cin_value_o   = cin_q;
  assign range_error_o = rerr_q;

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> cin_value_o == '0)
    else $error("range beat carries a nonzero value");

  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_RUN && pc_q == PC_RANGE)
    else $error("accepted beat did not start the program");

  a_mstep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> mstep_q <= MSTEP_LAST)
    else $error("multiplier step out of bounds");

  a_terms_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= JW'(MAX_TERMS))
    else $error("term counter above limit");

endmodule
